// ===== hdl/connection_slot_table_macros.svh =====
// Assertion macros for the connection slot table.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef CONNECTION_SLOT_TABLE_MACROS_SVH
`define CONNECTION_SLOT_TABLE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cst_pkg.sv =====
// Shared types and constants of the connection slot table.
// No dependencies; used by the controller, datapath and top level.
package cst_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int KEY_W     = 48;
    localparam int SLOT_W    = 6;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_FIND    = 2'd1,
        ACT_RELEASE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic direct;
        logic scan;
        logic finish;
        logic miss;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic needs_scan;
        logic hit;
        logic scan_end;
    } t_sts;

endpackage

// ===== hdl/cst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/cst_ctrl.sv =====
// Controller of the connection slot table: clear pass, idle, scan.
// Depends on cst_pkg; drives commands to cst_dpath and reads its status.
module cst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  cst_pkg::t_sts i_sts,
    output cst_pkg::t_cmd o_cmd
);

    cst_pkg::t_state r_state;
    cst_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cst_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            cst_pkg::S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = cst_pkg::S_IDLE;
                end
            end
            cst_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_sts.needs_scan) begin
                        o_cmd.load = 1'b1;
                        n_state    = cst_pkg::S_SCAN;
                    end else begin
                        o_cmd.direct = 1'b1;
                    end
                end
            end
            cst_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.finish = 1'b1;
                    n_state      = cst_pkg::S_IDLE;
                end else if (i_sts.scan_end) begin
                    o_cmd.miss = 1'b1;
                    n_state    = cst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cst_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

// ===== hdl/cst_dpath.sv =====
// Datapath of the connection slot table: slot RAM, scan counter, match, result.
// Depends on cst_pkg and cst_ram; commanded by cst_ctrl.
module cst_dpath #(
    parameter int SLOTS = cst_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cst_pkg::t_cmd             i_cmd,
    output cst_pkg::t_sts             o_sts,
    input  logic [1:0]                i_action,
    input  logic [31:0]               i_key_addr,
    input  logic [15:0]               i_key_port,
    input  logic [cst_pkg::SLOT_W-1:0] i_slot_in,
    output logic                      o_done,
    output logic [1:0]                o_status,
    output logic [cst_pkg::SLOT_W-1:0] o_slot_out
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int EXT_W  = ((IDX_W > cst_pkg::SLOT_W) ? IDX_W : cst_pkg::SLOT_W) + 1;
    localparam int WORD_W = cst_pkg::KEY_W + 1;

    logic [IDX_W:0]               r_idx;
    logic [IDX_W:0]               n_idx;
    logic                         r_chk_vld;
    logic [IDX_W-1:0]             r_chk_idx;
    logic [1:0]                   r_act;
    logic [cst_pkg::KEY_W-1:0]    r_key;
    logic                         r_done;
    cst_pkg::t_status             r_status;
    cst_pkg::t_status             n_status;
    logic [cst_pkg::SLOT_W-1:0]   r_slot_out;
    logic [cst_pkg::SLOT_W-1:0]   n_slot_out;
    logic                         n_done;

    logic                         rd_issue;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [WORD_W-1:0]            wr_data;
    logic [WORD_W-1:0]            rd_data;
    logic                         match;
    logic [EXT_W-1:0]             rel_ext;
    logic                         rel_ok;
    logic [EXT_W-1:0]             chk_ext;

    cst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.scan && rd_issue),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign rd_issue = r_idx < (IDX_W+1)'(SLOTS);
    assign rel_ext  = EXT_W'(i_slot_in);
    assign rel_ok   = rel_ext < EXT_W'(SLOTS);
    assign chk_ext  = EXT_W'(r_chk_idx);

    always_comb begin
        if (r_act == cst_pkg::ACT_ADD) begin
            match = !rd_data[WORD_W-1];
        end else begin
            match = rd_data[WORD_W-1] && (rd_data[cst_pkg::KEY_W-1:0] == r_key);
        end
    end

    assign o_sts.clr_last   = r_idx[IDX_W-1:0] == IDX_W'(SLOTS - 1);
    assign o_sts.needs_scan = (i_action == cst_pkg::ACT_ADD) || (i_action == cst_pkg::ACT_FIND);
    assign o_sts.hit        = r_chk_vld && match;
    assign o_sts.scan_end   = r_chk_vld && (r_chk_idx == IDX_W'(SLOTS - 1));

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.clr || i_cmd.load) begin
            n_idx = i_cmd.clr ? r_idx + 1'b1 : '0;
        end else if (i_cmd.scan && rd_issue) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[IDX_W-1:0];
        wr_data = '0;
        if (i_cmd.clr) begin
            wr_en = 1'b1;
        end else if (i_cmd.direct) begin
            wr_en   = (i_action == cst_pkg::ACT_RELEASE) && rel_ok;
            wr_addr = rel_ext[IDX_W-1:0];
        end else if (i_cmd.finish) begin
            wr_en   = r_act == cst_pkg::ACT_ADD;
            wr_addr = r_chk_idx;
            wr_data = {1'b1, r_key};
        end
    end

    always_comb begin
        n_done     = i_cmd.direct || i_cmd.finish || i_cmd.miss;
        n_status   = cst_pkg::ST_OK;
        n_slot_out = '0;
        if (i_cmd.finish) begin
            n_slot_out = chk_ext[cst_pkg::SLOT_W-1:0];
        end else if (i_cmd.miss) begin
            n_status = (r_act == cst_pkg::ACT_ADD) ? cst_pkg::ST_FULL : cst_pkg::ST_NOT_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_idx     <= n_idx;
            r_chk_vld <= i_cmd.scan && rd_issue && !i_cmd.load;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx  <= r_idx[IDX_W-1:0];
        r_status   <= n_status;
        r_slot_out <= n_slot_out;
        if (i_cmd.load) begin
            r_act <= i_action;
            r_key <= {i_key_addr, i_key_port};
        end
    end

    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_slot_out = r_slot_out;

endmodule

// ===== hdl/connection_slot_table.sv =====
// Connection slot table top level: cst_ctrl and cst_dpath.
// Add or find: scan the slot RAM from slot 0 to the first hit or the last slot, busy high.
// Release or unused action: result strobe the next cycle, busy stays low.
// The slot RAM scan reads one entry per cycle through its read port.
// Reset clears every slot in a clear pass with busy high; results cannot stall.
// Depends on cst_pkg, cst_ram and connection_slot_table_macros.svh.
`include "connection_slot_table_macros.svh"

module connection_slot_table #(
    parameter int SLOTS = cst_pkg::SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_action,
    input  logic [31:0]                i_key_addr,
    input  logic [15:0]                i_key_port,
    input  logic [cst_pkg::SLOT_W-1:0] i_slot_in,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [cst_pkg::SLOT_W-1:0] o_slot_out
);

    cst_pkg::t_cmd cmd;
    cst_pkg::t_sts sts;

    cst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cst_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_action   (i_action),
        .i_key_addr (i_key_addr),
        .i_key_port (i_key_port),
        .i_slot_in  (i_slot_in),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_slot_out (o_slot_out)
    );

    `CST_ASSERT_SAME(a_slot_zero_on_fail, o_done && (o_status != cst_pkg::ST_OK), o_slot_out == '0, "slot nonzero on failed item")
    `CST_ASSERT_NEXT(a_direct_result, start && !busy && (i_action != cst_pkg::ACT_ADD) && (i_action != cst_pkg::ACT_FIND), o_done && (o_status == cst_pkg::ST_OK), "release item gave no result")
    `CST_ASSERT_NEXT(a_scan_busy, start && !busy && ((i_action == cst_pkg::ACT_ADD) || (i_action == cst_pkg::ACT_FIND)), busy && !o_done, "scan item did not hold busy")

endmodule
